### hdl/dss_pkg.sv
// Package for the disk seek scheduler: widths, register and policy codes,
// and the structs passed between the front and back ends. No dependencies.
package dss_pkg;
  localparam int CYL_W = 16;
  localparam int TRV_W = 22;
  localparam int CNT_W = 7;
  localparam int IDX_W = 8;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SCAN  = 2'd1,
    POL_CSCAN = 2'd2,
    POL_RSVD  = 2'd3
  } policy_e;

  typedef enum logic [IDX_W-1:0] {
    REG_DISK_SIZE = 8'd0,
    REG_START     = 8'd1,
    REG_SWEEP     = 8'd2,
    REG_POLICY    = 8'd3
  } reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] low;
    logic [CYL_W-1:0] lo_max;
    logic [CYL_W-1:0] hi_min;
    logic [CYL_W-1:0] min_c;
    logic [CYL_W-1:0] max_c;
    logic [CYL_W-1:0] start;
    logic [CYL_W-1:0] last_cyl;
    policy_e          policy;
    logic             sweep_up;
  } batch_t;

  typedef struct packed {
    logic             valid;
    logic [CYL_W-1:0] data;
    logic [CNT_W-1:0] addr;
  } wr_t;
endpackage

### hdl/dss_if.sv
// Handshake interfaces of the disk seek scheduler: requests, results and
// configuration writes. Depends on dss_pkg.
interface dss_req_if;
  logic                      valid;
  logic                      ready;
  logic [dss_pkg::CYL_W-1:0] request_cylinder;
  logic                      last_request;
  modport source (output valid, request_cylinder, last_request, input ready);
  modport sink   (input valid, request_cylinder, last_request, output ready);
endinterface

interface dss_res_if;
  logic                      valid;
  logic                      ready;
  logic [dss_pkg::CYL_W-1:0] served_cylinder;
  logic [dss_pkg::TRV_W-1:0] total_travel;
  logic                      last_served;
  modport source (output valid, served_cylinder, total_travel, last_served, input ready);
  modport sink   (input valid, served_cylinder, total_travel, last_served, output ready);
endinterface

interface dss_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [dss_pkg::IDX_W-1:0] index;
  logic [dss_pkg::CYL_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/disk_seek_scheduler.sv
// Disk seek scheduler top level: configuration registers, front end and
// back end. Depends on dss_pkg, dss_if, dss_front and dss_back.
//
// Usage: write disk_size, start_cylinder, sweep_up and policy on the cfg
// channel (always ready) while idle. Send requests on req; the request
// with last_request set closes the batch. Requests beyond the last
// cylinder are clamped; requests past MAX_REQUESTS are dropped.
// Each request is taken into a sorted cell chain (append order for FCFS
// and the reserved code). After the last request the chain drains into
// the back end's memory, one entry per cycle while the back end is idle,
// then the next batch may load while the back end emits. Each result
// passes through a registered memory read ahead of the output register,
// and no further read is issued while one is pending; total_travel is
// nonzero only on the result with last_served set.
// If res stalls the output register holds and the walk pauses.
// Reset clears all control state and restores register defaults; the
// request memory needs no clearing.
module disk_seek_scheduler #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dss_req_if.sink   req_i,
  dss_res_if.source res_o,
  dss_cfg_if.sink   cfg_i
);
  localparam int CW = dss_pkg::CYL_W;

  logic [CW-1:0]    disk_size_q, start_q, last_cyl, start_eff;
  logic             sweep_q;
  dss_pkg::policy_e policy_q;
  dss_pkg::wr_t     wr;
  dss_pkg::batch_t  bat;
  logic             wr_ready, push_valid, push_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_size_q <= 16'hFFFF;
      start_q     <= '0;
      sweep_q     <= 1'b1;
      policy_q    <= dss_pkg::POL_FCFS;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dss_pkg::REG_DISK_SIZE: disk_size_q <= cfg_i.data;
        dss_pkg::REG_START:     start_q     <= cfg_i.data;
        dss_pkg::REG_SWEEP:     sweep_q     <= cfg_i.data[0];
        dss_pkg::REG_POLICY:    policy_q    <= dss_pkg::policy_e'(cfg_i.data[1:0]);
        default: ;
      endcase
    end
  end

  assign last_cyl  = (disk_size_q == '0) ? '0 : disk_size_q - CW'(1);
  assign start_eff = (start_q > last_cyl) ? last_cyl : start_q;

  dss_front #(.MAX_REQUESTS(MAX_REQUESTS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .req_cyl_i    (req_i.request_cylinder),
    .last_i       (req_i.last_request),
    .start_i      (start_eff),
    .last_cyl_i   (last_cyl),
    .policy_i     (policy_q),
    .sweep_up_i   (sweep_q),
    .wr_o         (wr),
    .wr_ready_i   (wr_ready),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (bat)
  );

  dss_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
    .clk_i, .rst_ni,
    .wr_i              (wr),
    .wr_ready_o        (wr_ready),
    .push_valid_i      (push_valid),
    .push_ready_o      (push_ready),
    .push_i            (bat),
    .out_valid_o       (res_o.valid),
    .out_ready_i       (res_o.ready),
    .served_cylinder_o (res_o.served_cylinder),
    .total_travel_o    (res_o.total_travel),
    .last_served_o     (res_o.last_served)
  );

  a_trav_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last_served |-> res_o.total_travel == '0)
    else $error("travel on non-final result");
  a_batch_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.last_request |=> !req_i.ready)
    else $error("request taken during drain");
  a_no_store_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.valid && wr_ready |-> !res_o.valid || res_o.last_served)
    else $error("store written while walking");
endmodule

### hdl/dss_front.sv
// Front end: clamps and inserts requests into a cell chain (sorted for
// SCAN/C-SCAN) and drains to the back end's store. Depends on dss_pkg.
module dss_front #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dss_pkg::CYL_W-1:0] req_cyl_i,
  input  logic                      last_i,
  input  logic [dss_pkg::CYL_W-1:0] start_i,
  input  logic [dss_pkg::CYL_W-1:0] last_cyl_i,
  input  dss_pkg::policy_e          policy_i,
  input  logic                      sweep_up_i,
  output dss_pkg::wr_t              wr_o,
  input  logic                      wr_ready_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output dss_pkg::batch_t           push_o
);
  localparam int CW = dss_pkg::CYL_W;
  localparam int NW = dss_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_XFER = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cell_q [MAX_REQUESTS];
  logic [CW-1:0]   cell_d [MAX_REQUESTS];
  logic [NW-1:0]   count_q, low_q, k_q;
  logic [CW-1:0]   lo_max_q, hi_min_q, min_q, max_q;
  logic [CW-1:0]   v;
  logic [MAX_REQUESTS-1:0] gt;
  logic            sort, acc, insert, shift;

  assign sort   = (policy_i == dss_pkg::POL_SCAN) || (policy_i == dss_pkg::POL_CSCAN);
  assign v      = (req_cyl_i > last_cyl_i) ? last_cyl_i : req_cyl_i;
  assign in_ready_o = (state_q == S_LOAD);
  assign acc    = in_valid_i && in_ready_o;
  assign insert = acc && (count_q < NW'(MAX_REQUESTS));
  assign shift  = (state_q == S_XFER) && wr_ready_i;

  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = sort && (NW'(i) < count_q) && (cell_q[i] > v);
    end
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      cell_d[i] = cell_q[i];
      if (shift) begin
        if (i < MAX_REQUESTS - 1) cell_d[i] = cell_q[(i + 1) % MAX_REQUESTS];
      end else if (insert) begin
        if (i > 0 && gt[(i + MAX_REQUESTS - 1) % MAX_REQUESTS]) begin
          cell_d[i] = cell_q[(i + MAX_REQUESTS - 1) % MAX_REQUESTS];
        end else if (gt[i] || (NW'(i) == count_q)) begin
          cell_d[i] = v;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: if (acc && last_i) state_d = S_XFER;
      S_XFER: if (shift && (k_q + NW'(1) == count_q)) state_d = S_PUSH;
      S_PUSH: if (push_ready_i) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_REQUESTS; i++) cell_q[i] <= cell_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      count_q  <= '0;
      low_q    <= '0;
      k_q      <= '0;
      lo_max_q <= '0;
      hi_min_q <= '1;
      min_q    <= '1;
      max_q    <= '0;
    end else begin
      state_q <= state_d;
      if (insert) begin
        count_q <= count_q + NW'(1);
        if (v <= start_i) begin
          low_q <= low_q + NW'(1);
          if (v > lo_max_q) lo_max_q <= v;
        end else if (v < hi_min_q) begin
          hi_min_q <= v;
        end
        if (v < min_q) min_q <= v;
        if (v > max_q) max_q <= v;
      end
      if (shift) k_q <= k_q + NW'(1);
      if (state_q == S_PUSH && push_ready_i) begin
        count_q  <= '0;
        low_q    <= '0;
        k_q      <= '0;
        lo_max_q <= '0;
        hi_min_q <= '1;
        min_q    <= '1;
        max_q    <= '0;
      end
    end
  end

  assign wr_o.valid = (state_q == S_XFER);
  assign wr_o.data  = cell_q[0];
  assign wr_o.addr  = k_q;

  assign push_valid_o    = (state_q == S_PUSH);
  assign push_o.n        = count_q;
  assign push_o.low      = low_q;
  assign push_o.lo_max   = lo_max_q;
  assign push_o.hi_min   = hi_min_q;
  assign push_o.min_c    = min_q;
  assign push_o.max_c    = max_q;
  assign push_o.start    = start_i;
  assign push_o.last_cyl = last_cyl_i;
  assign push_o.policy   = policy_i;
  assign push_o.sweep_up = sweep_up_i;
endmodule

### hdl/dss_back.sv
// Back end: holds one batch (sorted for SCAN and C-SCAN) in a memory,
// walks it in service order and computes head travel. Depends on dss_pkg.
module dss_back #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dss_pkg::wr_t              wr_i,
  output logic                      wr_ready_o,
  input  logic                      push_valid_i,
  output logic                      push_ready_o,
  input  dss_pkg::batch_t           push_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [dss_pkg::CYL_W-1:0] served_cylinder_o,
  output logic [dss_pkg::TRV_W-1:0] total_travel_o,
  output logic                      last_served_o
);
  localparam int CW = dss_pkg::CYL_W;
  localparam int TW = dss_pkg::TRV_W;
  localparam int NW = dss_pkg::CNT_W;
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [CW-1:0]   mem_q [MAX_REQUESTS];
  logic [CW-1:0]   rdata_q, prev_q, diff;
  dss_pkg::batch_t bat_q;
  logic            busy_q, pend_q, ovalid_q, olast_q;
  logic [NW-1:0]   k_q, a0, b0, la, addr;
  logic            da, db, sort, issue, fin;
  logic [TW-1:0]   acc_q, closed, otrav_q, travel;
  logic [CW-1:0]   ocyl_q;

  assign wr_ready_o   = !busy_q;
  assign push_ready_o = !busy_q;
  assign sort = (bat_q.policy == dss_pkg::POL_SCAN) || (bat_q.policy == dss_pkg::POL_CSCAN);

  always_comb begin
    a0 = '0; da = 1'b1; la = bat_q.n; b0 = '0; db = 1'b1;
    if (sort && bat_q.sweep_up) begin
      a0 = bat_q.low;
      la = bat_q.n - bat_q.low;
      if (bat_q.policy == dss_pkg::POL_SCAN) begin
        b0 = bat_q.low - NW'(1); db = 1'b0;
      end
    end else if (sort) begin
      a0 = bat_q.low - NW'(1); da = 1'b0;
      la = bat_q.low;
      if (bat_q.policy == dss_pkg::POL_SCAN) begin
        b0 = bat_q.low;
      end else begin
        b0 = bat_q.n - NW'(1); db = 1'b0;
      end
    end
    if (k_q < la) addr = da ? a0 + k_q : a0 - k_q;
    else          addr = db ? b0 + (k_q - la) : b0 - (k_q - la);
  end

  always_comb begin
    closed = '0;
    if (bat_q.sweep_up) begin
      closed = TW'(bat_q.last_cyl - bat_q.start);
      if (bat_q.policy == dss_pkg::POL_SCAN) begin
        if (bat_q.low != '0) closed = closed + TW'(bat_q.last_cyl - bat_q.min_c);
      end else begin
        closed = closed + TW'(bat_q.last_cyl);
        if (bat_q.low != '0) closed = closed + TW'(bat_q.lo_max);
      end
    end else begin
      closed = TW'(bat_q.start);
      if (bat_q.policy == dss_pkg::POL_SCAN) begin
        if (bat_q.low != bat_q.n) closed = closed + TW'(bat_q.max_c);
      end else begin
        closed = closed + TW'(bat_q.last_cyl);
        if (bat_q.low != bat_q.n) closed = closed + TW'(bat_q.last_cyl - bat_q.hi_min);
      end
    end
  end

  assign diff   = (rdata_q > prev_q) ? rdata_q - prev_q : prev_q - rdata_q;
  assign fin    = (k_q == bat_q.n);
  assign travel = sort ? closed : acc_q + TW'(diff);
  assign issue  = busy_q && !pend_q && (k_q < bat_q.n) && (!ovalid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.valid && wr_ready_o) mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    if (issue) rdata_q <= mem_q[addr[AW-1:0]];
    if (push_valid_i && push_ready_o) bat_q <= push_i;
    if (pend_q) begin
      ocyl_q  <= rdata_q;
      otrav_q <= fin ? travel : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
      k_q      <= '0;
      acc_q    <= '0;
      prev_q   <= '0;
    end else begin
      pend_q <= issue;
      if (out_ready_i) ovalid_q <= 1'b0;
      if (push_valid_i && push_ready_o) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        acc_q  <= '0;
        prev_q <= push_i.start;
      end
      if (issue) k_q <= k_q + NW'(1);
      if (pend_q) begin
        ovalid_q <= 1'b1;
        olast_q  <= fin;
        acc_q    <= acc_q + TW'(diff);
        prev_q   <= rdata_q;
        if (fin) busy_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = ovalid_q;
  assign served_cylinder_o = ocyl_q;
  assign total_travel_o    = otrav_q;
  assign last_served_o     = olast_q;
endmodule

### sim/testbench.sv
// Self-checking testbench for disk_seek_scheduler: directed table and batches,
// then random, checked against a scheduling predictor. Needs dss_pkg, dss_if.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [dss_pkg::CYL_W-1:0] cyl;
    logic                      last;
  } req_t;

  typedef struct {
    logic [dss_pkg::CYL_W-1:0] cyl;
    logic [dss_pkg::TRV_W-1:0] travel;
    logic                      last;
  } served_t;

  typedef struct {
    logic [dss_pkg::CYL_W-1:0] cyl;
    logic                      last;
    logic                      check_row;
    logic [dss_pkg::CYL_W-1:0] exp_cyl;
    logic [dss_pkg::TRV_W-1:0] exp_travel;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   res_stall_max = 3;

  dss_req_if req_ch ();
  dss_res_if res_ch ();
  dss_cfg_if cfg_ch ();

  disk_seek_scheduler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .res_o  (res_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [dss_pkg::CYL_W-1:0] disk_size_r = 16'hFFFF;
  logic [dss_pkg::CYL_W-1:0] start_r = '0;
  logic                      sweep_r = 1'b1;
  dss_pkg::policy_e          policy_r = dss_pkg::POL_FCFS;
  logic [dss_pkg::CYL_W-1:0] pending[$];
  served_t                   order_q[$];
  row_t                      table_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void schedule_batch();
    logic [dss_pkg::CYL_W-1:0] buf_a[$];
    logic [dss_pkg::CYL_W-1:0] endc, st, v, pos;
    logic [31:0] sum;
    int n, low, j;
    bit sorted;
    served_t s;
    endc = (disk_size_r == '0) ? '0 : disk_size_r - 16'd1;
    st = (start_r > endc) ? endc : start_r;
    buf_a = pending;
    n = buf_a.size();
    sum = 0;
    pos = st;
    low = 0;
    sorted = (policy_r == dss_pkg::POL_SCAN) || (policy_r == dss_pkg::POL_CSCAN);
    if (sorted) begin
      for (int i = 1; i < n; i++) begin
        v = buf_a[i];
        j = i;
        while (j > 0 && buf_a[j-1] > v) begin
          buf_a[j] = buf_a[j-1];
          j--;
        end
        buf_a[j] = v;
      end
      while (low < n && buf_a[low] <= st) low++;
    end
    for (int k = 0; k < n; k++) begin
      int idx;
      if (sorted) begin
        if (sweep_r) begin
          if (k < n - low) idx = low + k;
          else if (policy_r == dss_pkg::POL_SCAN) idx = low - 1 - (k - (n - low));
          else idx = k - (n - low);
          if (k == n - low) begin
            sum += endc - pos;
            pos = endc;
            if (policy_r == dss_pkg::POL_CSCAN) begin
              sum += endc;
              pos = '0;
            end
          end
        end else begin
          if (k < low) idx = low - 1 - k;
          else if (policy_r == dss_pkg::POL_SCAN) idx = k;
          else idx = n - 1 - (k - low);
          if (k == low) begin
            sum += pos;
            pos = '0;
            if (policy_r == dss_pkg::POL_CSCAN) begin
              sum += endc;
              pos = endc;
            end
          end
        end
      end else begin
        idx = k;
      end
      v = buf_a[idx];
      sum += (v > pos) ? v - pos : pos - v;
      pos = v;
      if (sorted && k == n - 1 && ((sweep_r && low == 0) || (!sweep_r && low == n))) begin
        if (sweep_r) sum += endc - pos;
        else sum += pos;
        if (policy_r == dss_pkg::POL_CSCAN) sum += endc;
      end
      s.cyl = v;
      s.travel = (k == n - 1) ? sum[dss_pkg::TRV_W-1:0] : '0;
      s.last = (k == n - 1);
      order_q.push_back(s);
    end
    pending.delete();
  endfunction

  function automatic void accept_request(input req_t r);
    logic [dss_pkg::CYL_W-1:0] endc, c;
    endc = (disk_size_r == '0) ? '0 : disk_size_r - 16'd1;
    c = (r.cyl > endc) ? endc : r.cyl;
    if (pending.size() < 64) pending.push_back(c);
    if (r.last) schedule_batch();
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    served_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (order_q.size() == 0) begin
        report("unexpected result", res_ch.served_cylinder, 0);
      end else begin
        e = order_q.pop_front();
        if (res_ch.served_cylinder !== e.cyl) report("served_cylinder", res_ch.served_cylinder, e.cyl);
        if (res_ch.total_travel !== e.travel) report("total_travel", res_ch.total_travel, e.travel);
        if (res_ch.last_served !== e.last) report("last_served", res_ch.last_served, e.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (res_stall_max == 0) begin
      res_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 9) < 7) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, res_stall_max) == 0);
    end
  end

  task automatic write_reg(input dss_pkg::reg_e idx, input logic [dss_pkg::CYL_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      dss_pkg::REG_DISK_SIZE: disk_size_r = val;
      dss_pkg::REG_START:     start_r = val;
      dss_pkg::REG_SWEEP:     sweep_r = val[0];
      default:                policy_r = dss_pkg::policy_e'(val[1:0]);
    endcase
  endtask

  task automatic configure(input logic [dss_pkg::CYL_W-1:0] ds,
                           input logic [dss_pkg::CYL_W-1:0] st,
                           input logic sw, input dss_pkg::policy_e pol);
    write_reg(dss_pkg::REG_DISK_SIZE, ds);
    write_reg(dss_pkg::REG_START, st);
    write_reg(dss_pkg::REG_SWEEP, {15'd0, sw});
    write_reg(dss_pkg::REG_POLICY, {14'd0, pol});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_request(input req_t r, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.request_cylinder <= r.cyl;
    req_ch.last_request <= r.last;
    do @(posedge clk_i); while (!req_ch.ready);
    accept_request(r);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    while (order_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_batch(input int maxn, input bit gaps);
    req_t r;
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, maxn) : $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: r.cyl = 16'hFFFF;
        1: r.cyl = '0;
        2: r.cyl = 16'($urandom_range(0, 40));
        default: r.cyl = 16'($urandom());
      endcase
      r.last = (i == n - 1);
      send_request(r, gaps);
    end
  endtask

  initial begin
    row_t row;
    served_t e;
    int sent;
    req_ch.valid = 1'b0;
    req_ch.request_cylinder = '0;
    req_ch.last_request = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: FCFS from cylinder 0
    table_q.push_back('{16'd100, 1'b0, 1'b0, 16'd100, 22'd0});
    table_q.push_back('{16'd50, 1'b1, 1'b1, 16'd50, 22'd150});
    table_q.push_back('{16'hFFFF, 1'b1, 1'b1, 16'hFFFE, 22'd65534});
    table_q.push_back('{16'd0, 1'b1, 1'b1, 16'd0, 22'd0});
    foreach (table_q[i]) begin
      row = table_q[i];
      send_request('{row.cyl, row.last}, 1'b0);
      e = order_q[$];
      if (row.check_row && (e.cyl !== row.exp_cyl || e.travel !== row.exp_travel))
        report("table row", i, row.exp_cyl);
    end
    drain();

    configure(16'd200, 16'd100, 1'b1, dss_pkg::POL_SCAN);
    foreach (table_q[i]) if (i < 2) send_request('{table_q[i].cyl, 1'b0}, 1'b0);
    send_request('{16'd100, 1'b0}, 1'b0);
    send_request('{16'd500, 1'b0}, 1'b0);
    send_request('{16'd150, 1'b1}, 1'b0);
    drain();
    configure(16'd200, 16'd100, 1'b0, dss_pkg::POL_CSCAN);
    send_request('{16'd20, 1'b0}, 1'b0);
    send_request('{16'd180, 1'b0}, 1'b0);
    send_request('{16'd100, 1'b1}, 1'b0);
    drain();
    configure(16'd0, 16'd5, 1'b1, dss_pkg::POL_RSVD);
    send_request('{16'd7, 1'b0}, 1'b0);
    send_request('{16'd0, 1'b1}, 1'b0);
    drain();
    configure(16'd1000, 16'd2000, 1'b0, dss_pkg::POL_SCAN);
    for (int i = 0; i < 66; i++) send_request('{16'($urandom_range(0, 1999)), i == 65}, 1'b0);
    drain();

    sent = 0;
    for (int phase = 0; phase < 12; phase++) begin
      res_stall_max = (phase % 4 == 3) ? 0 : (phase % 2 ? 8 : 2);
      case (phase % 4)
        0: configure(16'hFFFF, 16'hFFFE, phase[2], dss_pkg::policy_e'(phase % 3));
        1: configure(16'($urandom_range(1, 300)), 16'($urandom_range(0, 320)),
                     1'($urandom_range(0, 1)), dss_pkg::policy_e'($urandom_range(0, 3)));
        2: configure(16'd1, 16'd0, 1'($urandom_range(0, 1)),
                     dss_pkg::policy_e'($urandom_range(1, 2)));
        default: configure(16'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)),
                           dss_pkg::policy_e'($urandom_range(0, 3)));
      endcase
      repeat (4) begin
        random_batch(66, phase != 11);
        if (phase == 6) drain();
      end
      drain();
    end

    drain();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

### sim.f
hdl/dss_pkg.sv
hdl/dss_if.sv
hdl/dss_front.sv
hdl/dss_back.sv
hdl/disk_seek_scheduler.sv
sim/testbench.sv
